/* hw/rtl/ipf_pkg.sv */
// Shared types, character codes and helper functions for the IP address text formatter.
`timescale 1ns / 1ps
`default_nettype none
package ipf_pkg;

  localparam int HEXTETS = 8;
  localparam int HEXTET_W = 16;
  localparam int ADDR_W = 64;
  localparam int CHAR_W = 7;

  localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CH_HEX_ALPHA_BASE = 7'h57;
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3a;
  localparam logic [CHAR_W-1:0] CH_DOT = 7'h2e;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 7'h66;
  localparam logic [CHAR_W-1:0] CH_NINE = 7'h39;

  localparam logic OP_IPV6 = 1'b0;
  localparam logic OP_IPV4 = 1'b1;

  localparam logic [HEXTET_W-1:0] MAPPED_MARK = 16'hffff;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address_high;
    logic [ADDR_W-1:0] address_low;
  } ipf_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } ipf_out_t;

  typedef struct packed {
    logic [2:0] run_start;
    logic [3:0] run_len;
  } scan_res_t;

  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] base;
    base = (d < 4'd10) ? CH_ZERO : CH_HEX_ALPHA_BASE;
    return base + CHAR_W'(d);
  endfunction

  function automatic logic [1:0] hex_top_pos(input logic [HEXTET_W-1:0] h);
    logic [1:0] pos;
    if (h[15:12] != 4'd0) begin
      pos = 2'd3;
    end else if (h[11:8] != 4'd0) begin
      pos = 2'd2;
    end else if (h[7:4] != 4'd0) begin
      pos = 2'd1;
    end else begin
      pos = 2'd0;
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ipf_zero_scan.sv */
// Longest zero-hextet run finder, one hextet compared per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ipf_zero_scan import ipf_pkg::*; (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [HEXTETS-1:0][HEXTET_W-1:0] hextets,
  output logic                                 done,
  output scan_res_t                            res
);

  logic       active;
  logic [2:0] idx;
  logic [2:0] cur_start;
  logic [3:0] cur_len;

  logic [HEXTET_W-1:0] h;
  logic                is_zero;
  logic [3:0]          cur_len_next;
  logic [2:0]          cur_start_next;

  // hextet 0 sits in the top slot
  assign h = hextets[3'(3'd7 - idx)];
  assign is_zero = (h == '0);
  assign cur_len_next = is_zero ? 4'(cur_len + 4'd1) : 4'd0;
  assign cur_start_next = (is_zero && cur_len == 4'd0) ? idx : cur_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && idx == 3'd7) begin
        active <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= 3'd0;
      cur_len <= 4'd0;
      cur_start <= 3'd0;
      res.run_start <= 3'd0;
      res.run_len <= 4'd0;
    end else if (active) begin
      idx <= 3'(idx + 3'd1);
      cur_len <= cur_len_next;
      cur_start <= cur_start_next;
      // strict compare keeps the leftmost run on a tie
      if (cur_len_next > res.run_len) begin
        res.run_start <= cur_start_next;
        res.run_len <= cur_len_next;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ipf_dec_digit.sv */
// Octet digits: hundreds by subtraction, tens by constant reciprocal, ones as remainder.
`timescale 1ns / 1ps
`default_nettype none
module ipf_dec_digit import ipf_pkg::*; (
  input  wire logic [7:0] octet,
  input  wire logic [1:0] pos,
  output logic [1:0]      top_pos,
  output logic [3:0]      digit
);

  logic [1:0]  hund;
  logic [7:0]  rem8;
  logic [6:0]  rem7;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones7;

  always_comb begin
    if (octet >= 8'd200) begin
      hund = 2'd2;
      rem8 = octet - 8'd200;
    end else if (octet >= 8'd100) begin
      hund = 2'd1;
      rem8 = octet - 8'd100;
    end else begin
      hund = 2'd0;
      rem8 = octet;
    end
  end

  assign rem7 = rem8[6:0];
  // r / 10 == (r * 205) >> 11 for r below 100
  assign prod = 15'(rem7) * 15'd205;
  assign tens = prod[14:11];
  assign tens_x10 = {tens, 3'b000} - {2'b00, tens, 1'b0} + {1'b0, tens, 2'b00};
  assign ones7 = rem7 - tens_x10;

  assign top_pos = (octet >= 8'd100) ? 2'd2 : ((octet >= 8'd10) ? 2'd1 : 2'd0);

  always_comb begin
    case (pos)
      2'd2:    digit = {2'b00, hund};
      2'd1:    digit = tens;
      default: digit = ones7[3:0];
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/ip_address_text_formatter_core.sv */
// Top level: formats one IPv4 or IPv6 address into ASCII characters, one per strobe.
// IPv4: after accept, characters follow one per cycle; no new address is accepted before the last one.
// IPv6: zero-run scan in the ipf_zero_scan unit, then characters one per cycle
//   (up to 39 characters); no new address is accepted before the last one.
// busy stays high from accept until the final character is issued (n characters per item).
// Reset (synchronous, active high) returns to idle and drops the strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module ip_address_text_formatter_core import ipf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire ipf_in_t  cmd,
  output logic          busy,
  output logic          strobe,
  output ipf_out_t      result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_HEX   = 3'd2;
  localparam logic [2:0] S_COLON = 3'd3;
  localparam logic [2:0] S_COL1  = 3'd4;
  localparam logic [2:0] S_COL2  = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;
  localparam logic [2:0] S_DOT   = 3'd7;

  logic [2:0]        state;
  logic [ADDR_W-1:0] addr_high;
  logic [ADDR_W-1:0] addr_low;
  logic [31:0]       word32;
  logic [2:0]        grp;
  logic [1:0]        nib;
  logic [1:0]        oct;
  logic [1:0]        dig;
  logic              first;
  logic              to_v4;

  logic                             accept;
  logic [HEXTETS-1:0][HEXTET_W-1:0] hv;
  logic [3:0][7:0]                  ov;
  logic                             scan_done;
  scan_res_t                        scan_res;
  logic                             compress;
  logic                             mapped;
  logic [3:0]                       run_end;
  logic [HEXTET_W-1:0]              hx;
  logic [1:0]                       hex_pos;
  logic [3:0]                       hex_digit;
  logic [7:0]                       octet;
  logic [1:0]                       dec_top;
  logic [1:0]                       dec_pos;
  logic [3:0]                       dec_digit;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  assign hv = {addr_high, addr_low};
  assign ov = word32;

  ipf_zero_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && cmd.opcode == OP_IPV6),
    .hextets (hv),
    .done    (scan_done),
    .res     (scan_res)
  );

  assign compress = (scan_res.run_len > 4'd1);
  assign mapped = compress && scan_res.run_start == 3'd0 && scan_res.run_len == 4'd5
                  && hv[2] == MAPPED_MARK;
  assign run_end = 4'({1'b0, scan_res.run_start} + scan_res.run_len);

  assign hx = hv[3'(3'd7 - grp)];
  assign hex_pos = first ? hex_top_pos(hx) : nib;

  always_comb begin
    case (hex_pos)
      2'd3:    hex_digit = hx[15:12];
      2'd2:    hex_digit = hx[11:8];
      2'd1:    hex_digit = hx[7:4];
      default: hex_digit = hx[3:0];
    endcase
  end

  assign octet = ov[2'(2'd3 - oct)];
  assign dec_pos = first ? dec_top : dig;

  ipf_dec_digit u_dec (
    .octet   (octet),
    .pos     (dec_pos),
    .top_pos (dec_top),
    .digit   (dec_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr_high <= cmd.address_high;
            addr_low <= cmd.address_low;
            word32 <= cmd.address_low[31:0];
            oct <= 2'd0;
            first <= 1'b1;
            to_v4 <= 1'b0;
            state <= (cmd.opcode == OP_IPV4) ? S_DEC : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            grp <= 3'd0;
            first <= 1'b1;
            state <= (compress && scan_res.run_start == 3'd0) ? S_COL1 : S_HEX;
          end
        end
        S_HEX: begin
          strobe <= 1'b1;
          result.char_code <= hex_ascii(hex_digit);
          result.last_char <= 1'b0;
          if (hex_pos != 2'd0) begin
            nib <= 2'(hex_pos - 2'd1);
            first <= 1'b0;
          end else if (grp == 3'd7) begin
            result.last_char <= 1'b1;
            state <= S_IDLE;
          end else if (mapped && grp == 3'd5) begin
            // switch to dotted quad from hextets 6 and 7
            word32 <= {hv[1], hv[0]};
            to_v4 <= 1'b1;
            state <= S_COLON;
          end else if (compress && 3'(grp + 3'd1) == scan_res.run_start) begin
            grp <= 3'(grp + 3'd1);
            state <= S_COL1;
          end else begin
            grp <= 3'(grp + 3'd1);
            state <= S_COLON;
          end
        end
        S_COLON: begin
          strobe <= 1'b1;
          result.char_code <= CH_COLON;
          result.last_char <= 1'b0;
          first <= 1'b1;
          oct <= 2'd0;
          state <= to_v4 ? S_DEC : S_HEX;
        end
        S_COL1: begin
          strobe <= 1'b1;
          result.char_code <= CH_COLON;
          result.last_char <= 1'b0;
          state <= S_COL2;
        end
        S_COL2: begin
          strobe <= 1'b1;
          result.char_code <= CH_COLON;
          result.last_char <= (run_end == 4'd8);
          first <= 1'b1;
          grp <= run_end[2:0];
          state <= (run_end == 4'd8) ? S_IDLE : S_HEX;
        end
        S_DEC: begin
          strobe <= 1'b1;
          result.char_code <= CH_ZERO + CHAR_W'(dec_digit);
          result.last_char <= 1'b0;
          if (dec_pos != 2'd0) begin
            dig <= 2'(dec_pos - 2'd1);
            first <= 1'b0;
          end else if (oct == 2'd3) begin
            result.last_char <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DOT;
          end
        end
        S_DOT: begin
          strobe <= 1'b1;
          result.char_code <= CH_DOT;
          result.last_char <= 1'b0;
          oct <= 2'(oct + 2'd1);
          first <= 1'b1;
          state <= S_DEC;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_char |=> !strobe)
    else $error("character issued right after the final character");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_char |-> busy)
    else $error("idle while an address text is unfinished");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((result.char_code >= CH_ZERO && result.char_code <= CH_NINE)
             || (result.char_code >= CH_LOWER_A && result.char_code <= CH_LOWER_F)
             || result.char_code == CH_COLON || result.char_code == CH_DOT))
    else $error("character outside the address alphabet");
`endif

endmodule
`default_nettype wire

/* sim/ip_address_text_formatter_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the address text formatter: directed and random addresses, per-character compare.
module ip_address_text_formatter_core_tb;
  import ipf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  ipf_in_t  cmd = '0;
  logic     busy;
  logic     strobe;
  ipf_out_t result;

  ipf_out_t          expected_text[$];
  logic [CHAR_W-1:0] text_buf[$];
  ipf_out_t          next_char;
  int                error_count = 0;
  int                cycle_count = 0;
  int                idle_pct = 0;

  ip_address_text_formatter_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual %h last %b",
                 $time, result.char_code, result.last_char);
        error_count++;
      end else begin
        next_char = expected_text.pop_front();
        if (result.char_code !== next_char.char_code) begin
          $display("%0t: char_code mismatch: expected %h, actual %h",
                   $time, next_char.char_code, result.char_code);
          error_count++;
        end
        if (result.last_char !== next_char.last_char) begin
          $display("%0t: last_char mismatch: expected %b, actual %b",
                   $time, next_char.last_char, result.last_char);
          error_count++;
        end
      end
    end
  end

  function automatic void emit_hex(logic [HEXTET_W-1:0] v);
    logic       started;
    logic [3:0] d;
    started = 1'b0;
    for (int s = 12; s >= 0; s -= 4) begin
      d = v[s +: 4];
      if (d != 4'd0 || started || s == 0) begin
        if (d < 4'd10) begin
          text_buf.push_back(CH_ZERO + CHAR_W'(d));
        end else begin
          text_buf.push_back(CH_LOWER_A + CHAR_W'(d) - 7'd10);
        end
        started = 1'b1;
      end
    end
  endfunction

  function automatic void emit_dec(logic [7:0] v);
    if (v >= 8'd100) begin
      text_buf.push_back(CH_ZERO + CHAR_W'(v / 8'd100));
    end
    if (v >= 8'd10) begin
      text_buf.push_back(CH_ZERO + CHAR_W'((v / 8'd10) % 8'd10));
    end
    text_buf.push_back(CH_ZERO + CHAR_W'(v % 8'd10));
  endfunction

  function automatic void emit_dotted(logic [31:0] a);
    emit_dec(a[31:24]);
    text_buf.push_back(CH_DOT);
    emit_dec(a[23:16]);
    text_buf.push_back(CH_DOT);
    emit_dec(a[15:8]);
    text_buf.push_back(CH_DOT);
    emit_dec(a[7:0]);
  endfunction

  function automatic void emit_hextets(logic [0:7][HEXTET_W-1:0] hx, int from, int upto);
    for (int i = from; i < upto; i++) begin
      if (i != from) begin
        text_buf.push_back(CH_COLON);
      end
      emit_hex(hx[i]);
    end
  endfunction

  function automatic void format_address(ipf_in_t item);
    logic [0:7][HEXTET_W-1:0] hx;
    int                       best_start;
    int                       best_len;
    int                       cur_start;
    int                       cur_len;
    ipf_out_t                 entry;
    text_buf.delete();
    if (item.opcode == OP_IPV4) begin
      emit_dotted(item.address_low[31:0]);
    end else begin
      hx = {item.address_high, item.address_low};
      best_start = 0;
      best_len = 0;
      cur_start = 0;
      cur_len = 0;
      for (int i = 0; i < HEXTETS; i++) begin
        if (hx[i] != '0) begin
          if (cur_len > best_len) begin
            best_len = cur_len;
            best_start = cur_start;
          end
          cur_len = 0;
        end else begin
          if (cur_len == 0) begin
            cur_start = i;
          end
          cur_len++;
        end
      end
      if (cur_len > best_len) begin
        best_len = cur_len;
        best_start = cur_start;
      end
      if (best_len > 1) begin
        text_buf.push_back(CH_COLON);
        if (best_len == 5 && best_start == 0 && hx[5] == MAPPED_MARK) begin
          text_buf.push_back(CH_COLON);
          emit_hex(MAPPED_MARK);
          text_buf.push_back(CH_COLON);
          emit_dotted({hx[6], hx[7]});
        end else begin
          text_buf.delete(text_buf.size() - 1);
          emit_hextets(hx, 0, best_start);
          text_buf.push_back(CH_COLON);
          text_buf.push_back(CH_COLON);
          emit_hextets(hx, best_start + best_len, HEXTETS);
        end
      end else begin
        emit_hextets(hx, 0, HEXTETS);
      end
    end
    foreach (text_buf[i]) begin
      entry.char_code = text_buf[i];
      entry.last_char = (i == text_buf.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  task automatic send_address(input logic op, input logic [ADDR_W-1:0] hi,
                              input logic [ADDR_W-1:0] lo);
    ipf_in_t item;
    item.opcode = op;
    item.address_high = hi;
    item.address_low = lo;
    start <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (busy);
    format_address(item);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  function automatic logic [HEXTET_W-1:0] random_hextet();
    logic [HEXTET_W-1:0] h;
    case ($urandom_range(9))
      0, 1, 2, 3: h = '0;
      4, 5:       h = HEXTET_W'($urandom);
      6:          h = HEXTET_W'($urandom_range(15));
      7:          h = HEXTET_W'($urandom_range(255));
      8:          h = 16'hffff;
      default:    h = HEXTET_W'($urandom_range(4095));
    endcase
    return h;
  endfunction

  function automatic logic [ADDR_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_ipv4();
    send_address(OP_IPV4, random_word(), {$urandom, 32'h0000_0000});
    send_address(OP_IPV4, random_word(), {$urandom, 32'hffff_ffff});
    send_address(OP_IPV4, '1, {32'hffff_ffff, 32'h010a_64c8});
    send_address(OP_IPV4, '0, {32'h0000_0000, 32'h0963_c700});
  endtask

  task automatic test_ipv6_plain();
    send_address(OP_IPV6, '1, '1);
    send_address(OP_IPV6, 64'h1000_0100_0010_0001, 64'habcd_ef01_2345_6789);
    send_address(OP_IPV6, 64'h0001_0023_0456_789a, 64'hbcde_0f00_0000_0001);
    send_address(OP_IPV6, 64'h0000_0001_0002_0003, 64'h0004_0005_0006_0000);
  endtask

  task automatic test_zero_runs();
    send_address(OP_IPV6, '0, '0);
    send_address(OP_IPV6, 64'h0000_0000_0000_0001, 64'h0002_0003_0004_0005);
    send_address(OP_IPV6, 64'h0001_0002_0003_0004, 64'h0005_0000_0000_0000);
    send_address(OP_IPV6, 64'h0001_0002_0000_0000, 64'h0000_0003_0004_0005);
    send_address(OP_IPV6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004);
    send_address(OP_IPV6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003);
    send_address(OP_IPV6, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_address(OP_IPV6, 64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000);
  endtask

  task automatic test_mapped();
    send_address(OP_IPV6, 64'h0000_0000_0000_0000, 64'h0000_ffff_c0a8_0101);
    send_address(OP_IPV6, 64'h0000_0000_0000_0000, 64'h0000_ffff_0000_0000);
    send_address(OP_IPV6, 64'h0000_0000_0000_0000, 64'h0000_ffff_ffff_ffff);
    send_address(OP_IPV6, 64'h0000_0000_0000_0000, 64'h0000_fffe_0a0b_0c0d);
    send_address(OP_IPV6, 64'h0001_0000_0000_0000, 64'h0000_ffff_0102_0304);
    send_address(OP_IPV6, 64'h0000_0000_0000_0000, 64'h0000_0000_ffff_0102);
  endtask

  task automatic test_random(input int count, input int pct);
    logic [0:7][HEXTET_W-1:0] hx;
    idle_pct = pct;
    repeat (count) begin
      for (int i = 0; i < HEXTETS; i++) begin
        hx[i] = random_hextet();
      end
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          send_address(OP_IPV4, random_word(), random_word());
        end
        5, 6: begin
          hx[0:4] = '0;
          hx[5] = MAPPED_MARK;
          send_address(OP_IPV6, hx[0:3], hx[4:7]);
        end
        7: begin
          send_address(OP_IPV6, random_word(), random_word());
        end
        default: begin
          send_address(OP_IPV6, hx[0:3], hx[4:7]);
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_ipv4();
    test_ipv6_plain();
    test_zero_runs();
    test_mapped();
    test_random(70, 0);
    test_random(70, 84);
    test_random(60, 16);
    test_random(50, 0);
    @(posedge clk);
    start <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ipf_pkg.sv
hw/rtl/ipf_zero_scan.sv
hw/rtl/ipf_dec_digit.sv
hw/rtl/ip_address_text_formatter_core.sv
sim/ip_address_text_formatter_core_tb.sv
